[sv/srd_pkg.sv]
// Shared types and constants for the run-length sprite decoder.
// No dependencies; every other file imports this package.
package srd_pkg;

    localparam int HEIGHT_W = 10;
    localparam int COLUMN_W = 16;
    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 11;

    // A skip plus run at or above this limit is a malformed segment.
    localparam logic [16:0] SEG_LIMIT  = 17'd2048;
    localparam logic [15:0] COLOR_MASK = 16'h7fff;
    localparam logic [15:0] OPAQUE_BIT = 16'h8000;

    // Byte address of the image height register.
    localparam logic [1:0] ADDR_HEIGHT = 2'd0;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic                  valid;
        t_kind                 kind;
        logic [COLUMN_W-1:0]   column;
        logic [HEIGHT_W-1:0]   row;
        logic [WORD_W-1:0]     value;
    } t_result;

endpackage

[sv/srd_apb.sv]
// Configuration register block: holds the image height behind an APB-style port.
// Depends on srd_pkg.
module srd_apb
    import srd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [HEIGHT_W-1:0] o_image_height
);

    logic [HEIGHT_W-1:0] r_height;
    logic                w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && (paddr == ADDR_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_W'(1);
        end else if (w_write) begin
            r_height <= pwdata[HEIGHT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_HEIGHT) begin
            prdata = {{(32-HEIGHT_W){1'b0}}, r_height};
        end
    end

    assign o_image_height = r_height;

endmodule

[sv/srd_core.sv]
// Decode state machine: tracks phase, column, row and run count, and forms one result.
// Depends on srd_pkg.
module srd_core
    import srd_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [WORD_W-1:0]   i_word,
    input  logic [HEIGHT_W-1:0] i_image_height,
    output t_result             o_result
);

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_RUN   = 2'd1,
        PH_COLOR = 2'd2
    } t_phase;

    localparam logic [16:0]         MAX_DIM_W = 17'(MAX_DIMENSION);
    localparam logic [HEIGHT_W-1:0] CLAMP_H   = HEIGHT_W'(MAX_DIMENSION - 1);

    t_phase              r_phase,     n_phase;
    logic [COLUMN_W-1:0] r_column,    n_column;
    logic [HEIGHT_W-1:0] r_row,       n_row;
    logic [WORD_W-1:0]   r_held_skip, n_held_skip;
    logic [COUNT_W-1:0]  r_left,      n_left;
    logic                r_stopped,   n_stopped;

    logic [HEIGHT_W-1:0] w_eff_h;
    logic [16:0]         w_sum;
    logic [17:0]         w_reach;
    logic [HEIGHT_W:0]   w_row_inc;

    always_comb begin
        w_eff_h = (i_image_height == '0) ? HEIGHT_W'(1) : i_image_height;
        if ({{(17-HEIGHT_W){1'b0}}, w_eff_h} >= MAX_DIM_W) begin
            w_eff_h = CLAMP_H;
        end
    end

    assign w_sum     = {1'b0, r_held_skip} + {1'b0, i_word};
    assign w_reach   = {2'b00, r_column} + {1'b0, w_sum};
    assign w_row_inc = {1'b0, r_row} + (HEIGHT_W+1)'(1);

    always_comb begin
        n_phase     = r_phase;
        n_column    = r_column;
        n_row       = r_row;
        n_held_skip = r_held_skip;
        n_left      = r_left;
        n_stopped   = r_stopped;
        o_result    = '0;
        o_result.kind = KIND_PIXEL;

        if (i_fire && !r_stopped) begin
            case (r_phase)
                PH_SKIP: begin
                    n_held_skip = i_word;
                    n_phase     = PH_RUN;
                end
                PH_RUN: begin
                    if (w_sum >= SEG_LIMIT || w_reach > 18'h0ffff) begin
                        n_stopped      = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_ERROR;
                    end else if (w_sum != '0) begin
                        n_column = r_column + r_held_skip;
                        if (i_word != '0) begin
                            n_left  = i_word[COUNT_W-1:0];
                            n_phase = PH_COLOR;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        // Both zero: the row is finished.
                        n_column = '0;
                        n_row    = w_row_inc[HEIGHT_W-1:0];
                        n_phase  = PH_SKIP;
                        if (w_row_inc >= {1'b0, w_eff_h}) begin
                            n_stopped      = 1'b1;
                            o_result.valid = 1'b1;
                            o_result.kind  = KIND_DONE;
                        end
                    end
                end
                PH_COLOR: begin
                    o_result.valid  = 1'b1;
                    o_result.column = r_column;
                    o_result.row    = r_row;
                    o_result.value  = ((i_word & COLOR_MASK) != '0) ?
                                      (i_word | OPAQUE_BIT) : '0;
                    n_column = r_column + COLUMN_W'(1);
                    n_left   = r_left - COUNT_W'(1);
                    if (r_left <= COUNT_W'(1)) begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_column    <= '0;
            r_row       <= '0;
            r_held_skip <= '0;
            r_left      <= '0;
            r_stopped   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_column    <= n_column;
            r_row       <= n_row;
            r_held_skip <= n_held_skip;
            r_left      <= n_left;
            r_stopped   <= n_stopped;
        end
    end

endmodule

[sv/sprite_rle_decoder.sv]
// Top level of the run-length sprite decoder: input word register, decode core,
// result register and configuration port. Depends on srd_pkg, srd_apb, srd_core.
//
//   channel   direction  handshake                        payload
//   stream    in         i_stream_valid / o_stream_stall  i_stream_word
//   result    out        o_result_valid / i_result_stall  o_result_kind, o_pixel_column,
//                                                          o_pixel_row, o_pixel_value
//   config    in         psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A word taken from the stream waits in the input register and is decoded into the result
// register as soon as the result register is empty or being drained.
// One word is taken per cycle when the result side does not stall; the input register
// acts as a skid stage, so one word is still taken while a result waits.
// Reset is synchronous and active low; it clears the decode state and both valid flags.
// A stall on the result side holds the result register and then the input register.
module sprite_rle_decoder
    import srd_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Stream word input.
    input  logic                i_stream_valid,
    output logic                o_stream_stall,
    input  logic [WORD_W-1:0]   i_stream_word,
    // Result output.
    output logic                o_result_valid,
    input  logic                i_result_stall,
    output logic [1:0]          o_result_kind,
    output logic [COLUMN_W-1:0] o_pixel_column,
    output logic [HEIGHT_W-1:0] o_pixel_row,
    output logic [WORD_W-1:0]   o_pixel_value,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                r_in_valid;
    logic [WORD_W-1:0]   r_in_word;
    t_result             r_out;
    logic                w_fire;
    logic                w_accept;
    logic [HEIGHT_W-1:0] w_height;
    t_result             w_result;

    srd_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_image_height (w_height)
    );

    // The held word is decoded when the result register is empty or being drained.
    assign w_fire         = r_in_valid && (!r_out.valid || !i_result_stall);
    assign o_stream_stall = r_in_valid && !w_fire;
    assign w_accept       = i_stream_valid && !o_stream_stall;

    srd_core #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_word         (r_in_word),
        .i_image_height (w_height),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_stream_word;
        end
    end

    // Words that yield no result still pass through and leave the register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_fire) begin
            r_out <= w_result;
        end else if (!i_result_stall) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_result_valid = r_out.valid;
    assign o_result_kind  = r_out.kind;
    assign o_pixel_column = r_out.column;
    assign o_pixel_row    = r_out.row;
    assign o_pixel_value  = r_out.value;

`ifndef SYNTHESIS
    // A waiting result is never dropped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && i_result_stall |=> r_out.valid)
        else $error("result dropped while stalled");

    // The stream stalls only while a word is held.
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stream_stall |-> r_in_valid)
        else $error("stream stalled with empty input register");

    // A pixel is either transparent or carries the opaque bit.
    a_pixel_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.kind == KIND_PIXEL |-> r_out.value == '0 || r_out.value[15])
        else $error("pixel value without opaque bit");

    // Completion and error results carry zero fields.
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.kind != KIND_PIXEL |->
            r_out.column == '0 && r_out.row == '0 && r_out.value == '0)
        else $error("status result with nonzero fields");
`endif

endmodule

[dv/tb_sprite_rle_decoder.sv]
// Self-checking testbench for the run-length sprite decoder: directed and random streams.
// Depends on srd_pkg and the sprite_rle_decoder RTL; needs no other files.
module tb_sprite_rle_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import srd_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int LAST_COLUMN   = 65535;
    localparam int RANDOM_WORDS  = 1000;
    localparam int PHASE_WORDS   = 150;
    // A taken word passes through the input register into the result register; these settle
    // cycles cover a word that makes no result.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // Where the decoder stands inside a segment.
    typedef enum logic [1:0] {
        WANT_SKIP,
        WANT_RUN,
        WANT_COLOR
    } t_seg_state;

    // One result word as the decoder should send it.
    typedef struct packed {
        t_kind                kind;
        logic [COLUMN_W-1:0]  column;
        logic [HEIGHT_W-1:0]  row;
        logic [WORD_W-1:0]    value;
    } t_pixel_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_stream_valid = 1'b0;
    logic                o_stream_stall;
    logic [WORD_W-1:0]   i_stream_word  = '0;
    logic                o_result_valid;
    logic                i_result_stall = 1'b0;
    logic [1:0]          o_result_kind;
    logic [COLUMN_W-1:0] o_pixel_column;
    logic [HEIGHT_W-1:0] o_pixel_row;
    logic [WORD_W-1:0]   o_pixel_value;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [1:0]          paddr          = '0;
    logic [31:0]         pwdata         = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow of the decoder: the height register and the segment walk.
    logic [HEIGHT_W-1:0] height_reg  = 10'd1;
    t_seg_state          seg_state   = WANT_SKIP;
    logic [COLUMN_W-1:0] cur_col     = '0;
    logic [HEIGHT_W-1:0] cur_row     = '0;
    logic [WORD_W-1:0]   held_skip   = '0;
    logic [COUNT_W-1:0]  colors_left = '0;
    bit                  halted      = 1'b0;

    // Results that the decoder still owes, oldest first.
    t_pixel_result outputs_due[$];

    int    n_bad     = 0;
    int    n_words   = 0;
    int    n_pixels  = 0;
    int    n_heights = 0;
    string how_ended = "no terminal event";

    // When set, neither side idles, so the decoder runs at full rate.
    bit quiet      = 1'b0;
    int stall_left = 0;
    bit stall_hi   = 1'b0;

    sprite_rle_decoder #(
        .MAX_DIMENSION(MAX_DIM)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stream_valid (i_stream_valid),
        .o_stream_stall (o_stream_stall),
        .i_stream_word  (i_stream_word),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_result_kind  (o_result_kind),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_value  (o_pixel_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Colors lean toward the two transparent codes; the rest cover every bit.
    function automatic logic [WORD_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'h8000;
        return WORD_W'($urandom_range(0, 65535));
    endfunction

    // Appends one owed result behind the ones already waiting.
    function automatic void owe_result(input t_pixel_result res);
        outputs_due = {outputs_due, res};
    endfunction

    // Advances the shadow decoder by one accepted word and queues the result it causes.
    function automatic void decode_word(input logic [WORD_W-1:0] w);
        int unsigned   span;
        int unsigned   next_row;
        int unsigned   eff;
        t_pixel_result res;
        if (halted) return;
        case (seg_state)
            WANT_SKIP: begin
                held_skip = w;
                seg_state = WANT_RUN;
            end
            WANT_RUN: begin
                span = 32'(held_skip) + 32'(w);
                if (span >= 32'(SEG_LIMIT) || 32'(cur_col) + span > 32'(LAST_COLUMN)) begin
                    // Either the segment is too long or the column would pass its limit.
                    halted = 1'b1;
                    res = '{KIND_ERROR, 16'd0, 10'd0, 16'd0};
                    owe_result(res);
                end else if (span != 0) begin
                    cur_col += held_skip;
                    if (w != '0) begin
                        colors_left = w[COUNT_W-1:0];
                        seg_state   = WANT_COLOR;
                    end else begin
                        // An empty run only moves the column.
                        seg_state = WANT_SKIP;
                    end
                end else begin
                    // Zero skip and zero run close the row; the height is read here.
                    cur_col   = '0;
                    next_row  = 32'(cur_row) + 1;
                    seg_state = WANT_SKIP;
                    eff = 32'(height_reg);
                    if (eff == 0) eff = 1;
                    if (eff >= MAX_DIM) eff = MAX_DIM - 1;
                    if (next_row >= eff) begin
                        halted = 1'b1;
                        res = '{KIND_DONE, 16'd0, 10'd0, 16'd0};
                        owe_result(res);
                    end
                    cur_row = next_row[HEIGHT_W-1:0];
                end
            end
            default: begin
                res.kind   = KIND_PIXEL;
                res.column = cur_col;
                res.row    = cur_row;
                res.value  = ((w & COLOR_MASK) != '0) ? (w | OPAQUE_BIT) : 16'h0000;
                owe_result(res);
                cur_col = cur_col + COLUMN_W'(1);
                if (colors_left > '0) colors_left--;
                if (colors_left == '0) seg_state = WANT_SKIP;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        n_bad++;
        if (n_bad <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    // Sends one stream word, holds it until it is taken, then idles for a random gap.
    // Valid stays high when no gap follows, so back-to-back words never drop it.
    task automatic push_word(input logic [WORD_W-1:0] w);
        int gap;
        i_stream_valid <= 1'b1;
        i_stream_word  <= w;
        do @(posedge i_clk); while (o_stream_stall);
        decode_word(w);
        n_words++;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_stream_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A skip word, a run word and then run random colors.
    task automatic send_segment(input int skip, input int run);
        push_word(WORD_W'(skip));
        push_word(WORD_W'(run));
        for (int i = 0; i < run; i++) push_word(pick_color());
    endtask

    // Holds the stream until every owed result has arrived and the pipeline is empty.
    task automatic settle();
        i_stream_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A setup phase and an access phase held until pready, then the port returns to idle.
    task automatic apb_access(input logic wr, input logic [31:0] data,
                              output logic [31:0] got);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_HEIGHT;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the height while the decoder is idle, then reads it back.
    task automatic write_height(input logic [31:0] data);
        logic [31:0] got;
        settle();
        apb_access(1'b1, data, got);
        height_reg = data[HEIGHT_W-1:0];
        n_heights++;
        apb_access(1'b0, 32'd0, got);
        if (got[HEIGHT_W-1:0] !== height_reg)
            flag_mismatch("height readback", 32'(height_reg), 32'(got[HEIGHT_W-1:0]));
    endtask

    // Skip segments with empty runs until the next one would pass the last column.
    task automatic push_column_far();
        while (int'(cur_col) + 2047 <= LAST_COLUMN) send_segment(2047, 0);
    endtask

    // Result side: every taken result word is checked against the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_pixel_result want;
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            if (outputs_due.size() == 0) begin
                flag_mismatch("result with nothing owed, kind", 32'd0, 32'(o_result_kind));
            end else begin
                want = outputs_due.pop_front();
                if (o_result_kind !== want.kind)
                    flag_mismatch("result kind", 32'(want.kind), 32'(o_result_kind));
                if (o_pixel_column !== want.column)
                    flag_mismatch("pixel column", 32'(want.column), 32'(o_pixel_column));
                if (o_pixel_row !== want.row)
                    flag_mismatch("pixel row", 32'(want.row), 32'(o_pixel_row));
                if (o_pixel_value !== want.value)
                    flag_mismatch("pixel value", 32'(want.value), 32'(o_pixel_value));
                if (want.kind == KIND_PIXEL) n_pixels++;
            end
        end
    end

    // Result side back-pressure: alternating spells of stall and flow.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_hi   = !stall_hi && !quiet;
            stall_left = stall_hi ? pick_gap() : $urandom_range(0, 8);
        end
        i_result_stall <= stall_hi;
    end

    // Reset value of the height, then the largest height with junk in the upper bits.
    task automatic test_registers();
        logic [31:0] got;
        logic [31:0] data;
        apb_access(1'b0, 32'd0, got);
        if (got[HEIGHT_W-1:0] !== 10'd1)
            flag_mismatch("height after reset", 32'd1, 32'(got[HEIGHT_W-1:0]));
        data = $urandom;
        data[HEIGHT_W-1:0] = 10'd1023;
        write_height(data);
    endtask

    // Both transparent codes, the largest opaque colors and the smallest one.
    task automatic test_color_extremes();
        push_word(16'd0);
        push_word(16'd4);
        push_word(16'h0000);
        push_word(16'h8000);
        push_word(16'h7fff);
        push_word(16'hffff);
        push_word(16'd5);
        push_word(16'd1);
        push_word(16'h0001);
    endtask

    // The longest legal segment as an empty run, a row end, and a pixel far to the right.
    task automatic test_empty_run_and_row_end();
        push_word(16'd2047);
        push_word(16'd0);
        push_word(16'd0);
        push_word(16'd0);
        push_word(16'd2046);
        push_word(16'd1);
        push_word(16'h5555);
        push_word(16'd0);
        push_word(16'd0);
    endtask

    // A zero height written in the middle of a row; no row ends until it is replaced.
    task automatic test_zero_height();
        logic [31:0] data;
        send_segment(3, 2);
        data = $urandom;
        data[HEIGHT_W-1:0] = '0;
        write_height(data);
        send_segment(1, 1);
    endtask

    // Well-formed rows with random content, a new height every so often.
    task automatic test_random_rows();
        int          base;
        int          phase_start;
        int          phase_no;
        int          lo;
        int          kind;
        int          nseg;
        int          maxsum;
        int          run;
        int          skip;
        int          r;
        logic [31:0] data;
        base        = n_words;
        phase_start = n_words - PHASE_WORDS;
        phase_no    = 0;
        while (n_words - base < RANDOM_WORDS) begin
            if (n_words - phase_start >= PHASE_WORDS) begin
                // Heights stay well above the rows to come so the image never completes here.
                lo = int'(cur_row) + 200;
                if (lo > 1023) lo = 1023;
                data = $urandom;
                data[HEIGHT_W-1:0] = (phase_no % 3 == 0) ? 10'd1023
                                                         : HEIGHT_W'($urandom_range(lo, 1023));
                write_height(data);
                phase_start = n_words;
                phase_no++;
            end
            quiet = ($urandom_range(0, 9) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 6) begin
                // A wide row whose last pixel sits in the last usable column.
                push_column_far();
                maxsum = LAST_COLUMN - int'(cur_col);
                if (maxsum > 0) begin
                    run = $urandom_range(1, (maxsum < 4) ? maxsum : 4);
                    send_segment(maxsum - run, run);
                end
            end else if (kind >= 16) begin
                nseg = $urandom_range(1, 6);
                for (int s = 0; s < nseg; s++) begin
                    maxsum = LAST_COLUMN - int'(cur_col);
                    if (maxsum > 2047) maxsum = 2047;
                    if (maxsum == 0) break;
                    r = $urandom_range(0, 99);
                    run = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 6)
                                               : $urandom_range(7, 30);
                    if (run > maxsum) run = maxsum;
                    r = $urandom_range(0, 99);
                    skip = (r < 50) ? $urandom_range(0, 8) : (r < 90) ? $urandom_range(9, 200)
                                                                     : $urandom_range(201, 2047);
                    if (skip > maxsum - run) skip = maxsum - run;
                    // Keep a mid-row segment from reading as a row end.
                    if (skip + run == 0) run = 1;
                    send_segment(skip, run);
                end
            end
            // Rows of the remaining kind are empty: just the row end.
            send_segment(0, 0);
        end
        quiet = 1'b0;
    endtask

    // The one terminal event of the run: completion, a long segment or a column overflow.
    task automatic test_end_of_stream();
        logic [31:0] data;
        int          s;
        int          run;
        int          sum;
        case ($urandom_range(0, 2))
            0: begin
                how_ended = "image completion";
                data = $urandom;
                data[HEIGHT_W-1:0] = $urandom_range(0, 1) ? HEIGHT_W'(int'(cur_row) + 1)
                                                         : HEIGHT_W'($urandom_range(0,
                                                                      32'(cur_row)));
                write_height(data);
                send_segment($urandom_range(0, 20), $urandom_range(1, 5));
                send_segment(0, 0);
            end
            1: begin
                how_ended = "segment length error";
                s = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 65535);
                if (s < 2048)
                    run = $urandom_range(0, 1) ? 2048 - s : $urandom_range(2048 - s, 65535);
                else
                    run = $urandom_range(0, 65535);
                push_word(WORD_W'(s));
                push_word(WORD_W'(run));
            end
            default: begin
                how_ended = "column overflow error";
                push_column_far();
                sum = $urandom_range(LAST_COLUMN - int'(cur_col) + 1, 2047);
                s   = $urandom_range(0, sum);
                push_word(WORD_W'(s));
                push_word(WORD_W'(sum - s));
            end
        endcase
    endtask

    // Once stopped, the decoder must swallow everything without a result.
    task automatic test_after_stop();
        for (int i = 0; i < 24; i++) push_word(WORD_W'($urandom_range(0, 65535)));
    endtask

    task automatic finish_drain();
        int spin;
        spin = 0;
        i_stream_valid <= 1'b0;
        while (outputs_due.size() != 0 && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (10) @(posedge i_clk);
        if (outputs_due.size() != 0) begin
            flag_mismatch("results never delivered, count", 32'd0, outputs_due.size());
            n_bad += outputs_due.size() - 1;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        test_color_extremes();
        test_empty_run_and_row_end();
        test_zero_height();
        test_random_rows();
        test_end_of_stream();
        test_after_stop();
        finish_drain();
        $display("Decoded %0d stream words into %0d checked pixels over %0d rows,",
                 n_words, n_pixels, cur_row);
        $display("with %0d height settings; the stream ended in %s.", n_heights, how_ended);
        if (n_bad == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest run with every gap and stall at its longest.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
